// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared widths, register indexes and types for the PI target tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int TGT_W   = 24;   // integer target
  localparam int GAIN_W  = 16;   // unsigned Q4.12
  localparam int FLOOR_W = 24;   // signed integer floor
  localparam int TRK_W   = 33;   // signed Q24.8 tracked value
  localparam int SUM_W   = 48;   // signed Q39.8 error sum
  localparam int CIDX_W  = 2;    // config register index
  localparam int CDAT_W  = 24;   // config write data (widest register)

  // config register indexes
  localparam logic [CIDX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FLOOR_VALUE   = 2'd2;

  // command codes
  localparam logic CMD_TARGET = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // reset values
  localparam logic [GAIN_W-1:0]         PROP_GAIN_RST     = 16'd4096;
  localparam logic [GAIN_W-1:0]         INTEGRAL_GAIN_RST = 16'd0;
  localparam logic signed [FLOOR_W-1:0] FLOOR_VALUE_RST   = 24'sd0;

  typedef struct packed {
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         integral_gain;
    logic signed [FLOOR_W-1:0] floor_value;
  } cfg_t;

  typedef struct packed {
    logic signed [TRK_W-1:0] tracked;
    logic signed [SUM_W-1:0] error_sum;
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/ptt_cfg.sv =====
// ----------------------------------------------------------------------------
// ptt_cfg
// Configuration register file: gains and floor, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [ptt_pkg::CIDX_W-1:0]    wr_index,
  input  wire logic [ptt_pkg::CDAT_W-1:0]    wr_data,
  output ptt_pkg::cfg_t                      cfg
);

  ptt_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.prop_gain     <= ptt_pkg::PROP_GAIN_RST;
      regs.integral_gain <= ptt_pkg::INTEGRAL_GAIN_RST;
      regs.floor_value   <= ptt_pkg::FLOOR_VALUE_RST;
    end else if (wr_en) begin
      case (wr_index)
        ptt_pkg::REG_PROP_GAIN:     regs.prop_gain     <= wr_data[ptt_pkg::GAIN_W-1:0];
        ptt_pkg::REG_INTEGRAL_GAIN: regs.integral_gain <= wr_data[ptt_pkg::GAIN_W-1:0];
        ptt_pkg::REG_FLOOR_VALUE:   regs.floor_value   <= $signed(wr_data);
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== hdl/ptt_step.sv =====
// ----------------------------------------------------------------------------
// ptt_step
// One PI update: error, saturating sum, PI step, limited move, saturation, floor clamp; or clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_step (
  input  wire ptt_pkg::cfg_t                 cfg,
  input  wire ptt_pkg::state_t               cur,
  input  wire logic                          command,
  input  wire logic [ptt_pkg::TGT_W-1:0]     target,
  output ptt_pkg::state_t                    nxt
);

  localparam int DIFF_W = 35;
  localparam int P_W    = 52;
  localparam int Q_W    = 65;
  localparam int TOT_W  = 66;
  localparam int STEP_W = TOT_W - 12;
  localparam int NV_W   = STEP_W + 1;
  localparam int SRAW_W = ptt_pkg::SUM_W + 1;

  localparam logic signed [NV_W-1:0]   TRK_HI = (NV_W'(1) <<< (ptt_pkg::TRK_W-1)) - NV_W'(1);
  localparam logic signed [NV_W-1:0]   TRK_LO = -(NV_W'(1) <<< (ptt_pkg::TRK_W-1));
  localparam logic signed [SRAW_W-1:0] SUM_HI =
    (SRAW_W'(1) <<< (ptt_pkg::SUM_W-1)) - SRAW_W'(1);
  localparam logic signed [SRAW_W-1:0] SUM_LO = -(SRAW_W'(1) <<< (ptt_pkg::SUM_W-1));

  logic signed [DIFF_W-1:0]          tgt_q, trk_x, diff;
  logic signed [SRAW_W-1:0]          sum_raw;
  logic signed [ptt_pkg::SUM_W-1:0]  sum_sat;
  logic signed [P_W-1:0]             p;
  logic signed [Q_W-1:0]             q;
  logic signed [TOT_W-1:0]           total;
  logic signed [STEP_W-1:0]          step, diff_x, move;
  logic signed [NV_W-1:0]            nv_raw;
  logic signed [ptt_pkg::TRK_W-1:0]  nv_sat, floor_q;

  always_comb begin
    tgt_q   = $signed({3'b000, target, 8'h00});
    trk_x   = $signed({{(DIFF_W-ptt_pkg::TRK_W){cur.tracked[ptt_pkg::TRK_W-1]}}, cur.tracked});
    diff    = tgt_q - trk_x;

    sum_raw = $signed({cur.error_sum[ptt_pkg::SUM_W-1], cur.error_sum})
            + $signed({{(SRAW_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    if (sum_raw > SUM_HI)      sum_sat = SUM_HI[ptt_pkg::SUM_W-1:0];
    else if (sum_raw < SUM_LO) sum_sat = SUM_LO[ptt_pkg::SUM_W-1:0];
    else                       sum_sat = sum_raw[ptt_pkg::SUM_W-1:0];

    // exact sum of both products, floored by 4096
    p     = $signed({{(P_W-ptt_pkg::GAIN_W){1'b0}}, cfg.prop_gain})
          * $signed({{(P_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    q     = $signed({{(Q_W-ptt_pkg::GAIN_W){1'b0}}, cfg.integral_gain})
          * $signed({{(Q_W-ptt_pkg::SUM_W){sum_sat[ptt_pkg::SUM_W-1]}}, sum_sat});
    total = $signed({{(TOT_W-P_W){p[P_W-1]}}, p}) + $signed({q[Q_W-1], q});
    step  = total[TOT_W-1:12];

    diff_x = $signed({{(STEP_W-DIFF_W){diff[DIFF_W-1]}}, diff});
    if (diff > 0) move = (diff_x < step) ? diff_x : step;
    else          move = (diff_x > step) ? diff_x : step;

    nv_raw = $signed({{(NV_W-DIFF_W){trk_x[DIFF_W-1]}}, trk_x})
           + $signed({move[STEP_W-1], move});
    if (nv_raw > TRK_HI)      nv_sat = TRK_HI[ptt_pkg::TRK_W-1:0];
    else if (nv_raw < TRK_LO) nv_sat = TRK_LO[ptt_pkg::TRK_W-1:0];
    else                      nv_sat = nv_raw[ptt_pkg::TRK_W-1:0];

    floor_q = $signed({cfg.floor_value[ptt_pkg::FLOOR_W-1], cfg.floor_value, 8'h00});

    if (command == ptt_pkg::CMD_CLEAR) begin
      nxt.tracked   = '0;
      nxt.error_sum = '0;
    end else if (nv_sat < floor_q) begin
      nxt.tracked   = floor_q;
      nxt.error_sum = '0;
    end else begin
      nxt.tracked   = nv_sat;
      nxt.error_sum = sum_sat;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptt_outbuf.sv =====
// ----------------------------------------------------------------------------
// ptt_outbuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_outbuf (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire logic signed [ptt_pkg::TRK_W-1:0]    push_data,
  output logic                                     full,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ptt_pkg::TRK_W-1:0]         out_data
);

  logic                              ov, sv;
  logic signed [ptt_pkg::TRK_W-1:0]  od, sd;
  logic                              pop;

  assign pop = ov && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (pop) begin
      if (sv) begin
        sv <= push;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      if (!ov) ov <= 1'b1;
      else     sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sv) begin
        od <= sd;
        if (push) sd <= push_data;
      end else if (push) begin
        od <= push_data;
      end
    end else if (push) begin
      if (!ov) od <= push_data;
      else     sd <= push_data;
    end
  end

  assign full      = sv;
  assign out_valid = ov;
  assign out_data  = od;

endmodule

`default_nettype wire

// ===== hdl/pi_target_tracker.sv =====
// ----------------------------------------------------------------------------
// pi_target_tracker
// PI tracker of an integer target with step limit, floor clamp and clear.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid / in_stall      | command (1), target (24, unsigned)
//  out     | out_valid / out_stall    | tracked_value (33, signed Q24.8)
//  cfg     | cfg_valid / cfg_ready    | cfg_index (2), cfg_data (24)
//
//  One transaction per clock is sustained while out_stall stays low. A target
//  is captured in the input register; the whole PI update (two multiplies,
//  add, clamp) then runs from that register and lands in the output buffer.
//  The tracked/sum feedback through that single update sets the rate.
//  Reset (rst, synchronous) zeroes tracked value and sum, loads register
//  defaults and empties the pipeline. While out_stall holds, one result
//  spills into the skid entry; in_stall rises only once that entry is full.
//  cfg_ready is always high; writes are expected only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_target_tracker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input transactions
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic [ptt_pkg::TGT_W-1:0]           target,
  // result transactions
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ptt_pkg::TRK_W-1:0]         tracked_value,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ptt_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [ptt_pkg::CDAT_W-1:0]          cfg_data
);

  ptt_pkg::cfg_t   cfg;
  ptt_pkg::state_t state, state_next;

  // input register
  logic                          s1_valid;
  logic                          s1_command;
  logic [ptt_pkg::TGT_W-1:0]     s1_target;

  logic buf_full;
  logic advance;
  logic in_take;

  assign cfg_ready = 1'b1;

  ptt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // stage 1 moves on as long as the skid entry is free
  assign advance  = s1_valid && !buf_full;
  assign in_stall = s1_valid && buf_full;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take || advance) begin
      s1_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command <= command;
      s1_target  <= target;
    end
  end

  // PI update against the live state
  ptt_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .command (s1_command),
    .target  (s1_target),
    .nxt     (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  ptt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (state_next.tracked),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (tracked_value)
  );

endmodule

`default_nettype wire
